FILE: hdl/sim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sim_pkg
// Shared types, sizes and helpers of the strided index mapper.
// ----------------------------------------------------------------------------
package sim_pkg;

  localparam int MAX_DIMS     = 4;
  localparam int DIM_BITS     = 16;
  localparam int INDEX_W      = 32;
  localparam int STORE_W      = 36;
  localparam int CFG_W        = 64;
  localparam int NDIMS_W      = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int DIV_STEP     = 4;
  localparam int DIV_STAGES   = INDEX_W / DIV_STEP;
  localparam int PACK_W       = MAX_DIMS * DIM_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_SIZES    = 3'd0,
    REG_DIM_STRIDES  = 3'd1,
    REG_NUM_DIMS     = 3'd2,
    REG_TOTAL_ELEMS  = 3'd3,
    REG_BASE_OFFSET  = 3'd4
  } sim_reg_t;

  // Partial division state: dividend shifting out, quotient shifting in.
  typedef struct packed {
    logic [INDEX_W-1:0]  num;
    logic [DIM_BITS-1:0] rem;
  } sim_div_t;

  // Data that travels beside the dividers.
  typedef struct packed {
    logic [INDEX_W-1:0]                 li;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0]  coord;
  } sim_side_t;

  // Restoring division, DIV_STEP quotient bits.
  function automatic sim_div_t sim_div_step(sim_div_t a, logic [DIM_BITS-1:0] den);
    sim_div_t            r;
    logic [DIM_BITS:0]   wide;
    r = a;
    for (int i = 0; i < DIV_STEP; i++) begin
      wide  = {r.rem, r.num[INDEX_W-1]};
      r.num = {r.num[INDEX_W-2:0], 1'b0};
      if (wide >= {1'b0, den}) begin
        wide     = wide - {1'b0, den};
        r.num[0] = 1'b1;
      end
      r.rem = wide[DIM_BITS-1:0];
    end
    return r;
  endfunction

  // Size of a dimension as a divisor: unused or zero reads as one.
  function automatic logic [DIM_BITS-1:0] sim_eff_size(logic [PACK_W-1:0] sizes,
                                                        logic [NDIMS_W-1:0] nd, int d);
    logic [DIM_BITS-1:0] s;
    s = sizes[d*DIM_BITS +: DIM_BITS];
    if (NDIMS_W'(d) >= nd || s == '0) begin
      s = DIM_BITS'(1);
    end
    return s;
  endfunction

  // Stride of a dimension: unused reads as zero.
  function automatic logic [DIM_BITS-1:0] sim_eff_stride(logic [PACK_W-1:0] strides,
                                                          logic [NDIMS_W-1:0] nd, int d);
    logic [DIM_BITS-1:0] s;
    s = strides[d*DIM_BITS +: DIM_BITS];
    if (NDIMS_W'(d) >= nd) begin
      s = '0;
    end
    return s;
  endfunction

endpackage

FILE: hdl/strided_index_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_index_map
// Maps a row-major logical index of a strided view to a storage index.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid, in_stall, in_logical_index    | in
//  result  | out_valid, out_stall, out_storage_index,| out
//          | out_out_of_range                        |
//  config  | cfg_we, cfg_idx, cfg_wdata              | in
//
//  One beat enters per cycle while in_stall is low. The pipeline is a chain of
//  pipelined dividers (DIV_STEP quotient bits a stage), one multiply stage
//  and the output register.
//  Reset clears all valid bits and loads the register defaults.
//  A stall at the output while a result is held freezes the whole pipeline;
//  in_stall follows it.
module strided_index_map
  import sim_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [INDEX_W-1:0]   in_logical_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STORE_W-1:0]   out_storage_index,
  output logic                 out_out_of_range,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Configuration registers
  logic [PACK_W-1:0]  sizes_r;
  logic [PACK_W-1:0]  strides_r;
  logic [NDIMS_W-1:0] num_dims_r;
  logic [INDEX_W-1:0] total_r;
  logic [INDEX_W-1:0] base_r;
  logic [NDIMS_W-1:0] nd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sizes_r    <= '0;
      strides_r  <= '0;
      num_dims_r <= NDIMS_W'(1);
      total_r    <= '0;
      base_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DIM_SIZES:   sizes_r    <= PACK_W'(cfg_wdata);
        REG_DIM_STRIDES: strides_r  <= PACK_W'(cfg_wdata);
        REG_NUM_DIMS:    num_dims_r <= cfg_wdata[NDIMS_W-1:0];
        REG_TOTAL_ELEMS: total_r    <= cfg_wdata[INDEX_W-1:0];
        REG_BASE_OFFSET: base_r     <= cfg_wdata[INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the dimension count.
  assign nd = (num_dims_r > NDIMS_W'(MAX_DIMS)) ? NDIMS_W'(MAX_DIMS) : num_dims_r;

  // Advance every stage together unless a finished beat is held at the output.
  logic out_valid_r;
  logic adv;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Divider chain: peel coordinates off from the last dimension down.
  logic               chain_vld  [MAX_DIMS];
  logic [INDEX_W-1:0] chain_num  [MAX_DIMS];
  sim_side_t          chain_side [MAX_DIMS];

  assign chain_vld[0]  = in_valid;
  assign chain_num[0]  = in_logical_index;
  assign chain_side[0] = '{li: in_logical_index, coord: '0};

  for (genvar k = 0; k < MAX_DIMS - 1; k++) begin : g_dim
    logic                div_vld;
    logic [INDEX_W-1:0]  div_quo;
    logic [DIM_BITS-1:0] div_rem;
    sim_side_t           div_side;
    sim_side_t           side_upd;

    sim_div_pipe u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (chain_vld[k]),
      .in_num   (chain_num[k]),
      .in_den   (sim_eff_size(sizes_r, nd, MAX_DIMS - 1 - k)),
      .in_side  (chain_side[k]),
      .out_vld  (div_vld),
      .out_quo  (div_quo),
      .out_rem  (div_rem),
      .out_side (div_side)
    );

    // Drop the remainder into this dimension's coordinate.
    always_comb begin
      side_upd = div_side;
      side_upd.coord[MAX_DIMS - 1 - k] = div_rem;
    end

    assign chain_vld[k+1]  = div_vld;
    assign chain_num[k+1]  = div_quo;
    assign chain_side[k+1] = side_upd;
  end

  // Multiply stage: the leading quotient is dimension 0's coordinate.
  logic                      mult_vld_r;
  logic [INDEX_W-1:0]        mult_li_r;
  logic [STORE_W-1:0]        prod_r   [MAX_DIMS];
  logic [STORE_W-1:0]        prod_nxt [MAX_DIMS];
  logic [INDEX_W+DIM_BITS-1:0] wide_prod [MAX_DIMS];

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (d == 0) begin
        wide_prod[d] = chain_num[MAX_DIMS-1] * sim_eff_stride(strides_r, nd, d);
      end else begin
        wide_prod[d] = INDEX_W'(chain_side[MAX_DIMS-1].coord[d])
                       * sim_eff_stride(strides_r, nd, d);
      end
      prod_nxt[d] = STORE_W'(wide_prod[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_vld_r <= 1'b0;
    end else if (adv) begin
      mult_vld_r <= chain_vld[MAX_DIMS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mult_li_r <= chain_side[MAX_DIMS-1].li;
      for (int d = 0; d < MAX_DIMS; d++) begin
        prod_r[d] <= prod_nxt[d];
      end
    end
  end

  // Sum stage into the output register; wrap modulo 2^36.
  logic [STORE_W-1:0] storage_r;
  logic [STORE_W-1:0] storage_nxt;
  logic               oor_r;

  always_comb begin
    storage_nxt = STORE_W'(base_r);
    for (int d = 0; d < MAX_DIMS; d++) begin
      storage_nxt = storage_nxt + prod_r[d];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= mult_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      storage_r <= storage_nxt;
      oor_r     <= (mult_li_r >= total_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_storage_index = storage_r;
  assign out_out_of_range  = oor_r;

endmodule

FILE: hdl/sim_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sim_div_pipe
// Pipelined divider of a 32-bit index by a size, DIV_STEP bits a stage.
// ----------------------------------------------------------------------------
module sim_div_pipe
  import sim_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  logic [INDEX_W-1:0]  in_num,
  input  logic [DIM_BITS-1:0] in_den,
  input  sim_side_t           in_side,
  output logic                out_vld,
  output logic [INDEX_W-1:0]  out_quo,
  output logic [DIM_BITS-1:0] out_rem,
  output sim_side_t           out_side
);

  logic      vld_r  [DIV_STAGES];
  sim_div_t  dat_r  [DIV_STAGES];
  sim_side_t side_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic      vld_prev;
    sim_div_t  dat_prev;
    sim_side_t side_prev;

    if (s == 0) begin : g_first
      assign vld_prev  = in_vld;
      assign dat_prev  = '{num: in_num, rem: '0};
      assign side_prev = in_side;
    end else begin : g_next
      assign vld_prev  = vld_r[s-1];
      assign dat_prev  = dat_r[s-1];
      assign side_prev = side_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dat_r[s]  <= sim_div_step(dat_prev, in_den);
        side_r[s] <= side_prev;
      end
    end
  end

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign out_quo  = dat_r[DIV_STAGES-1].num;
  assign out_rem  = dat_r[DIV_STAGES-1].rem;
  assign out_side = side_r[DIV_STAGES-1];

endmodule

FILE: hdl/sim_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sim_checker
// Port-level checks of the strided index mapper.
// ----------------------------------------------------------------------------
module sim_checker
  import sim_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [STORE_W-1:0] out_storage_index,
  input logic               out_out_of_range
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_storage_index) && $stable(out_out_of_range))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule

bind strided_index_map sim_checker u_sim_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_storage_index (out_storage_index),
  .out_out_of_range  (out_out_of_range)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_index_map testbench
// Checks the strided view index mapper against its own storage-index
// predictor: reset defaults and directed views first, then random views and
// indices, under random gaps on both sides, a long output hold and a full drain.
// ----------------------------------------------------------------------------
module testbench;
  import sim_pkg::*;

  localparam int DRAIN_CYCLES = (MAX_DIMS - 1) * DIV_STAGES + 8;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [INDEX_W-1:0]   in_logical_index;
  logic                 out_valid;
  logic                 out_stall;
  logic [STORE_W-1:0]   out_storage_index;
  logic                 out_out_of_range;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  strided_index_map u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_logical_index  (in_logical_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_storage_index (out_storage_index),
    .out_out_of_range  (out_out_of_range),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata)
  );

  typedef struct packed {
    logic [STORE_W-1:0] storage;
    logic               oor;
  } mapped_t;

  // Shadow copy of the view registers, as the block holds them.
  logic [PACK_W-1:0]  view_sizes;
  logic [PACK_W-1:0]  view_strides;
  logic [NDIMS_W-1:0] view_ndims;
  logic [31:0]        view_total;
  logic [31:0]        view_base;

  mapped_t pending_maps[$];
  int      mismatches;
  int      hold_left;      // long output hold requested by a test
  int      stall_left;
  bit      quiet;          // no idling on either side

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("strided_index_map regression: fail");
    $finish;
  end

  // Divisor and stride of one dimension; unused dimensions are 1 / 0.
  function automatic logic [63:0] dim_size(int d);
    logic [DIM_BITS-1:0] s;
    int                  nd;
    nd = (view_ndims > MAX_DIMS) ? MAX_DIMS : int'(view_ndims);
    s  = view_sizes[d*DIM_BITS +: DIM_BITS];
    if (d >= nd || s == '0) return 64'd1;
    return 64'(s);
  endfunction

  function automatic logic [63:0] dim_stride(int d);
    int nd;
    nd = (view_ndims > MAX_DIMS) ? MAX_DIMS : int'(view_ndims);
    if (d >= nd) return 64'd0;
    return 64'(view_strides[d*DIM_BITS +: DIM_BITS]);
  endfunction

  // Peel one coordinate per dimension, outermost first; the leading
  // quotient is unbounded and the sum wraps at the storage width.
  function automatic mapped_t map_index(logic [INDEX_W-1:0] li);
    mapped_t     m;
    logic [63:0] rem, acc, div, q;
    rem = 64'(li);
    acc = 64'(view_base);
    for (int d = 0; d < MAX_DIMS; d++) begin
      div = 64'd1;
      for (int j = d + 1; j < MAX_DIMS; j++) div = div * dim_size(j);
      q   = rem / div;
      rem = rem % div;
      acc = (acc + q * dim_stride(d)) & ((64'd1 << STORE_W) - 1);
    end
    m.storage = acc[STORE_W-1:0];
    m.oor     = (li >= view_total);
    return m;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random stall runs, or a long hold when a test asks.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 99) < 20) stall_left <= pick_gap();
    end
  end

  // Result checker: compare each accepted beat with the oldest prediction.
  always @(posedge clk) begin
    mapped_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_maps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: storage=%h oor=%b",
                   out_storage_index, out_out_of_range);
      end else begin
        want = pending_maps.pop_front();
        if (out_storage_index !== want.storage || out_out_of_range !== want.oor) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: storage exp %h got %h, oor exp %b got %b",
                     want.storage, out_storage_index, want.oor, out_out_of_range);
        end
      end
    end
  end

  // Offer one index, hold it until accepted, then idle for a random gap.
  task automatic send_index(logic [INDEX_W-1:0] li);
    int gap;
    in_valid         <= 1'b1;
    in_logical_index <= li;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_maps.push_back(map_index(li));
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every prediction to be matched, let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all five view registers on consecutive edges (block is idle).
  task automatic apply_view(logic [PACK_W-1:0] sizes, logic [PACK_W-1:0] strides,
                            logic [NDIMS_W-1:0] nd, logic [31:0] total,
                            logic [31:0] base);
    cfg_we <= 1'b1;
    cfg_idx <= REG_DIM_SIZES;    cfg_wdata <= CFG_W'(sizes);   @(posedge clk);
    cfg_idx <= REG_DIM_STRIDES;  cfg_wdata <= CFG_W'(strides); @(posedge clk);
    cfg_idx <= REG_NUM_DIMS;     cfg_wdata <= CFG_W'(nd);      @(posedge clk);
    cfg_idx <= REG_TOTAL_ELEMS;  cfg_wdata <= CFG_W'(total);   @(posedge clk);
    cfg_idx <= REG_BASE_OFFSET;  cfg_wdata <= CFG_W'(base);    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    view_sizes   = sizes;
    view_strides = strides;
    view_ndims   = nd;
    view_total   = total;
    view_base    = base;
  endtask

  // Defaults after reset: one dimension, all sizes and strides zero.
  task automatic test_reset_view();
    send_index('0);
    send_index('1);
    send_index(32'h8000_0001);
    drain();
  endtask

  task automatic test_directed_views();
    // Four dims 3x4x5x6, indices at the edges of the element count.
    apply_view({16'd6, 16'd5, 16'd4, 16'd3}, {16'd1, 16'd7, 16'd40, 16'd300},
               3'd4, 32'd360, 32'd1000);
    send_index(32'd0);
    send_index(32'd1);
    send_index(32'd123);
    send_index(32'd359);
    send_index(32'd360);
    send_index('1);
    drain();
    // Zero sizes and no dimensions in use: storage is just the base.
    apply_view({16'd0, 16'd9, 16'd0, 16'd2}, '1, 3'd0, 32'd0, 32'hFFFF_FFFF);
    send_index(32'd5);
    send_index(32'hFFFF_FFFF);
    drain();
    // num_dims past the maximum, extreme sizes and strides.
    apply_view('1, '1, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_index(32'hFFFF_FFFF);
    send_index(32'hFFFF_FFFE);
    send_index(32'd0);
    send_index(32'h5555_AAAA);
    drain();
    // Zero size inside the view, one and three dimensions.
    apply_view({16'd7, 16'd0, 16'd3, 16'd2}, {16'hFFFF, 16'd0, 16'd5, 16'h8000},
               3'd3, 32'd6, 32'd0);
    send_index(32'd5);
    send_index(32'd6);
    send_index(32'h0001_0000);
    drain();
    apply_view({48'd0, 16'd10}, {48'd0, 16'd3}, 3'd1, 32'd10, 32'd17);
    send_index(32'd9);
    send_index(32'd10);
    drain();
  endtask

  // Random view: mostly small sizes so indices land inside the view.
  task automatic pick_view();
    logic [PACK_W-1:0]  sizes, strides;
    logic [NDIMS_W-1:0] nd;
    logic [63:0]        prod;
    logic [31:0]        total, base;
    int                 r;
    prod = 64'd1;
    nd   = NDIMS_W'($urandom_range(0, 7));
    for (int d = 0; d < MAX_DIMS; d++) begin
      r = $urandom_range(0, 99);
      if (r < 70)      sizes[d*DIM_BITS +: DIM_BITS] = DIM_BITS'($urandom_range(1, 8));
      else if (r < 82) sizes[d*DIM_BITS +: DIM_BITS] = '0;
      else             sizes[d*DIM_BITS +: DIM_BITS] = DIM_BITS'($urandom);
      r = $urandom_range(0, 9);
      strides[d*DIM_BITS +: DIM_BITS] = (r == 0) ? '0 : (r == 1) ? '1
                                      : DIM_BITS'($urandom);
      if (d < ((nd > MAX_DIMS) ? MAX_DIMS : nd) && sizes[d*DIM_BITS +: DIM_BITS] != 0)
        prod = prod * sizes[d*DIM_BITS +: DIM_BITS];
    end
    r = $urandom_range(0, 9);
    total = (r < 7) ? ((prod > 64'hFFFF_FFFF) ? '1 : prod[31:0])
          : (r == 7) ? '0 : (r == 8) ? '1 : $urandom;
    r = $urandom_range(0, 9);
    base = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
    apply_view(sizes, strides, nd, total, base);
  endtask

  task automatic send_random_indices(int count);
    logic [63:0] span;
    for (int i = 0; i < count; i++) begin
      span = 64'(view_total) + 64'(view_total) / 4 + 2;
      if ($urandom_range(0, 99) < 75) send_index(32'($urandom % span));
      else                            send_index($urandom);
    end
  endtask

  task automatic test_random_views();
    for (int p = 0; p < 10; p++) begin
      quiet = (p % 4 == 3);
      pick_view();
      send_random_indices(110);
      drain();
    end
    quiet = 1'b0;
  endtask

  // Long output hold while the sender keeps offering: the pipe fills up.
  task automatic test_backpressure();
    pick_view();
    hold_left = 200;
    quiet     = 1'b1;
    send_random_indices(80);
    quiet = 1'b0;
    send_random_indices(40);
    drain();
  endtask

  // Sender pauses until all results are back, then resumes on the same view.
  task automatic test_pause_resume();
    pick_view();
    send_random_indices(40);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_maps.size() != 0) @(posedge clk);
    send_random_indices(40);
    drain();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_logical_index = '0;
    out_stall        = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_DIM_SIZES;
    cfg_wdata        = '0;
    mismatches       = 0;
    hold_left        = 0;
    quiet            = 1'b0;
    view_sizes       = '0;
    view_strides     = '0;
    view_ndims       = 3'd1;
    view_total       = '0;
    view_base        = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_view();
    test_directed_views();
    test_random_views();
    test_backpressure();
    test_pause_resume();

    if (mismatches == 0) begin
      $display("strided_index_map regression: pass");
    end else begin
      $display("strided_index_map regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/sim_pkg.sv
hdl/sim_div_pipe.sv
hdl/strided_index_map.sv
hdl/sim_checker.sv
tb/sv/testbench.sv
